>>> rtl/b64e_pkg.sv
// shared types, constants and the character table for the base64 stream encoder
`default_nettype none
package b64e_pkg;

  localparam int RUN_MAX = 5;
  localparam int RUN_CNT_W = 3;
  localparam int COL_W = 10;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 1'b1;

  localparam logic [COL_W-1:0] LINE_LENGTH_RESET = 10'd76;

  localparam logic [7:0] PAD_CHAR     = 8'h3D;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
    logic       end_of_message;
  } out_item_t;

  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] chars;
    logic [RUN_CNT_W-1:0]    count;
    logic                    eom;
  } run_t;

  typedef struct packed {
    logic [15:0]      pending_bytes;
    logic [1:0]       group_fill;
    logic [COL_W-1:0] line_column;
  } enc_state_t;

  // standard alphabet lookup
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/b64e_quad_enc.sv
// combinational group encoder: byte collection, quad build, pad and line wrap
`default_nettype none
module b64e_quad_enc (
  input  b64e_pkg::in_item_t              item,
  input  b64e_pkg::enc_state_t            cur,
  input  logic                            wrap_enable,
  input  logic [b64e_pkg::COL_W-1:0]      line_length,
  output logic                            emit,
  output b64e_pkg::run_t                  run,
  output b64e_pkg::enc_state_t            nxt
);
  import b64e_pkg::*;

  logic [1:0]       fill;
  logic [7:0]       b0;
  logic [7:0]       b1;
  logic [7:0]       b2;
  logic [COL_W:0]   col_sum;
  logic             brk;

  always_comb begin
    fill = (cur.group_fill == 2'd3) ? 2'd2 : cur.group_fill;
    emit = (fill == 2'd2) || item.last_byte;

    b0 = (fill == 2'd0) ? item.data_byte : cur.pending_bytes[15:8];
    b1 = (fill == 2'd1) ? item.data_byte : cur.pending_bytes[7:0];
    b2 = item.data_byte;
    if (fill == 2'd0) b1 = 8'h00;
    if (fill != 2'd2) b2 = 8'h00;

    col_sum = {1'b0, cur.line_column} + (COL_W+1)'(4);
    brk     = wrap_enable && (col_sum >= {1'b0, line_length});

    run.chars[0] = b64_char(b0[7:2]);
    run.chars[1] = b64_char({b0[1:0], b1[7:4]});
    run.chars[2] = (fill != 2'd0) ? b64_char({b1[3:0], b2[7:6]}) : PAD_CHAR;
    run.chars[3] = (fill == 2'd2) ? b64_char(b2[5:0]) : PAD_CHAR;
    run.chars[4] = NEWLINE_CHAR;
    run.count    = brk ? RUN_CNT_W'(5) : RUN_CNT_W'(4);
    run.eom      = item.last_byte;

    nxt = cur;
    if (!emit) begin
      nxt.group_fill = fill + 2'd1;
      if (fill == 2'd0) begin
        nxt.pending_bytes = {item.data_byte, 8'h00};
      end else begin
        nxt.pending_bytes = {cur.pending_bytes[15:8], item.data_byte};
      end
    end else begin
      nxt.pending_bytes = 16'h0000;
      nxt.group_fill    = 2'd0;
      if (!wrap_enable || brk || item.last_byte) begin
        nxt.line_column = '0;
      end else begin
        nxt.line_column = col_sum[COL_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/b64e_char_ser.sv
// run register that hands out one character per transaction
`default_nettype none
module b64e_char_ser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  b64e_pkg::run_t       run,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output b64e_pkg::out_item_t  out_data
);
  import b64e_pkg::*;

  logic                      run_valid;
  logic [RUN_MAX-1:0][7:0]   chars;
  logic [RUN_CNT_W-1:0]      remain;
  logic                      eom;
  logic                      fire;
  logic                      at_last;

  assign at_last   = (remain == RUN_CNT_W'(1));
  assign fire      = run_valid && out_ready;
  assign free      = !run_valid || (fire && at_last);
  assign out_valid = run_valid;

  assign out_data.out_char       = chars[0];
  assign out_data.last_of_run    = at_last;
  assign out_data.end_of_message = at_last && eom;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      remain    <= '0;
    end else if (load) begin
      run_valid <= 1'b1;
      remain    <= run.count;
    end else if (fire) begin
      run_valid <= !at_last;
      remain    <= remain - RUN_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chars <= run.chars;
      eom   <= run.eom;
    end else if (fire) begin
      chars <= {8'h00, chars[RUN_MAX-1:1]};
    end
  end

endmodule
`default_nettype wire

>>> rtl/base64_stream_encoder_unit.sv
// top level of the base64 stream encoder with optional line wrapping
// a group-completing byte shows its first character in the cycle after its transaction
// a byte that only fills the group is taken even while a run drains; a group gives 4 characters, 5 with newline
// the sustained rate is set by the single-character output port of the run register
// reset: synchronous active-high rst clears group state, wrap off, line length 76
`default_nettype none
module base64_stream_encoder_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  b64e_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output b64e_pkg::out_item_t                   out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [b64e_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [b64e_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import b64e_pkg::*;

  // configuration registers
  logic             wrap_enable;
  logic [COL_W-1:0] line_length;

  // group and line state
  enc_state_t state;
  enc_state_t state_next;

  logic  emit;
  run_t  run;
  logic  ser_free;
  logic  in_fire;

  // config writes are always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_enable <= 1'b0;
      line_length <= LINE_LENGTH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WRAP_ENABLE: wrap_enable <= cfg_data[0];
        CFG_LINE_LENGTH: line_length <= cfg_data[COL_W-1:0];
        default: ;
      endcase
    end
  end

  b64e_quad_enc u_enc (
    .item        (in_data),
    .cur         (state),
    .wrap_enable (wrap_enable),
    .line_length (line_length),
    .emit        (emit),
    .run         (run),
    .nxt         (state_next)
  );

  // a byte that only fills the group needs no output slot, so it never waits
  assign in_ready = ser_free || !emit;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // run register drains one character per output transaction
  b64e_char_ser u_ser (
    .clk       (clk),
    .rst       (rst),
    .load      (in_fire && emit),
    .run       (run),
    .free      (ser_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> tb/tb_base64_stream_encoder_unit.sv
`timescale 1ns / 100ps
// self-checking testbench for the base64 stream encoder unit, with a built-in encoder predictor
module tb_base64_stream_encoder_unit;
  import b64e_pkg::*;

  // run shape
  localparam int IDLE_LIMIT  = 1000;  // cycles with no transaction on any channel
  localparam int CFG_PAUSE   = 4;     // settle time before a register write
  localparam int TAIL_CYCLES = 10;    // watch for stray characters at the end
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_BYTES = 19;
  localparam int DIR_ROWS    = 24;
  localparam int MAX_PRINTS  = 200;

  localparam logic [0:63][7:0] B64_ALPHA =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // line lengths for the random phases, the last phase picks its own
  localparam logic [COL_W-1:0] LEN_PICK [NUM_PHASES] = '{
    10'd4, 10'd1023, 10'd76, 10'd0, 10'd1020, 10'd3, 10'd13, 10'd76
  };

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_e;

  // one directed step: a byte transaction or a register write,
  // with an optional typed-in expected character run
  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    logic [7:0]             data_byte;
    logic                   last_byte;
    logic [2:0]             n_typed;
    logic [39:0]            typed;
  } stim_row_t;

  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    // reset settings: wrap off, so plain quads and padded tails
    '{ROW_BYTE, CFG_WRAP_ENABLE, 10'd0, 8'h00, 1'b1, 3'd4, {8'h00, "AA=="}},
    '{ROW_BYTE, CFG_WRAP_ENABLE, 10'd0, 8'hFF, 1'b1, 3'd4, {8'h00, "/w=="}},
    '{ROW_BYTE, CFG_WRAP_ENABLE, 10'd0, 8'hFF, 1'b0, 3'd0, 40'h0},
    '{ROW_BYTE, CFG_WRAP_ENABLE, 10'd0, 8'hFF, 1'b1, 3'd4, {8'h00, "//8="}},
    '{ROW_BYTE, CFG_WRAP_ENABLE, 10'd0, 8'h00, 1'b0, 3'd0, 40'h0},
    '{ROW_BYTE, CFG_WRAP_ENABLE, 10'd0, 8'h00, 1'b0, 3'd0, 40'h0},
    '{ROW_BYTE, CFG_WRAP_ENABLE, 10'd0, 8'h00, 1'b0, 3'd4, {8'h00, "AAAA"}},
    '{ROW_BYTE, CFG_WRAP_ENABLE, 10'd0, 8'hFF, 1'b0, 3'd0, 40'h0},
    '{ROW_BYTE, CFG_WRAP_ENABLE, 10'd0, 8'hFF, 1'b0, 3'd0, 40'h0},
    '{ROW_BYTE, CFG_WRAP_ENABLE, 10'd0, 8'hFF, 1'b1, 3'd4, {8'h00, "////"}},
    // shortest line: newline after every quad, also on the message end
    '{ROW_CFG,  CFG_WRAP_ENABLE, 10'd1, 8'h00, 1'b0, 3'd0, 40'h0},
    '{ROW_CFG,  CFG_LINE_LENGTH, 10'd4, 8'h00, 1'b0, 3'd0, 40'h0},
    '{ROW_BYTE, CFG_WRAP_ENABLE, 10'd0, 8'h4D, 1'b0, 3'd0, 40'h0},
    '{ROW_BYTE, CFG_WRAP_ENABLE, 10'd0, 8'h61, 1'b0, 3'd0, 40'h0},
    '{ROW_BYTE, CFG_WRAP_ENABLE, 10'd0, 8'h6E, 1'b0, 3'd0, 40'h0},
    '{ROW_BYTE, CFG_WRAP_ENABLE, 10'd0, 8'h00, 1'b1, 3'd0, 40'h0},
    // two quads per line, the two-byte tail fills the line
    '{ROW_CFG,  CFG_LINE_LENGTH, 10'd8, 8'h00, 1'b0, 3'd0, 40'h0},
    '{ROW_BYTE, CFG_WRAP_ENABLE, 10'd0, 8'h01, 1'b0, 3'd0, 40'h0},
    '{ROW_BYTE, CFG_WRAP_ENABLE, 10'd0, 8'h02, 1'b0, 3'd0, 40'h0},
    '{ROW_BYTE, CFG_WRAP_ENABLE, 10'd0, 8'h03, 1'b0, 3'd0, 40'h0},
    '{ROW_BYTE, CFG_WRAP_ENABLE, 10'd0, 8'h04, 1'b0, 3'd0, 40'h0},
    '{ROW_BYTE, CFG_WRAP_ENABLE, 10'd0, 8'h05, 1'b1, 3'd0, 40'h0},
    // zero line length still breaks after each quad
    '{ROW_CFG,  CFG_LINE_LENGTH, 10'd0, 8'h00, 1'b0, 3'd0, 40'h0},
    '{ROW_BYTE, CFG_WRAP_ENABLE, 10'd0, 8'h80, 1'b1, 3'd0, 40'h0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // predictor copy of the encoder state and its registers, at reset values
  logic             enc_wrap     = 1'b0;
  logic [COL_W-1:0] enc_line_len = LINE_LENGTH_RESET;
  logic [15:0]      enc_held     = '0;
  logic [1:0]       enc_fill     = '0;
  logic [COL_W-1:0] enc_column   = '0;

  out_item_t char_q[$];  // characters still owed by the encoder, oldest first

  int mismatches  = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  int gap_max     = 4;
  int rx_mode     = 2;
  int rx_hold     = 0;

  always #5 clk = ~clk;

  base64_stream_encoder_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predicts the character run caused by one byte and advances the state
  function automatic int encode_byte(input logic [7:0] b, input logic lst,
                                     output logic [4:0][7:0] run);
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [10:0] colsum;
    int          nbytes;
    int          n;
    run = '0;
    // group still open: just hold the byte
    if (enc_fill < 2'd2 && !lst) begin
      if (enc_fill == 2'd0) begin
        enc_held = {b, 8'h00};
      end else begin
        enc_held[7:0] = b;
      end
      enc_fill = enc_fill + 2'd1;
      return 0;
    end
    nbytes = int'(enc_fill) + 1;
    b0 = (enc_fill == 2'd0) ? b : enc_held[15:8];
    b1 = (enc_fill == 2'd1) ? b : enc_held[7:0];
    b2 = b;
    if (nbytes < 2) b1 = 8'h00;
    if (nbytes < 3) b2 = 8'h00;
    run[0] = B64_ALPHA[b0[7:2]];
    run[1] = B64_ALPHA[{b0[1:0], b1[7:4]}];
    run[2] = (nbytes >= 2) ? B64_ALPHA[{b1[3:0], b2[7:6]}] : PAD_CHAR;
    run[3] = (nbytes >= 3) ? B64_ALPHA[b2[5:0]] : PAD_CHAR;
    n = 4;
    // the column sum is one bit wider than the column, so 1021..1023 break at 1024
    if (enc_wrap) begin
      colsum = {1'b0, enc_column} + 11'd4;
      if (colsum >= {1'b0, enc_line_len}) begin
        run[4] = NEWLINE_CHAR;
        n = 5;
        colsum = '0;
      end
      enc_column = colsum[COL_W-1:0];
    end else begin
      enc_column = '0;
    end
    enc_held = '0;
    enc_fill = '0;
    if (lst) enc_column = '0;
    return n;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatches < MAX_PRINTS) begin
      $display("mismatch at %0t: %s got 0x%02h expected 0x%02h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  // one byte transaction; the sender runs in bursts, with random gaps when gap_max is above zero
  task automatic send_byte(input logic [7:0] b, input logic lst,
                           input logic [2:0] n_typed, input logic [39:0] typed);
    logic [4:0][7:0] run;
    int              n;
    int              gap;
    gap = 0;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gap_max > 0) gap = $urandom_range(1, gap_max);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: lst};
    do @(posedge clk); while (!in_ready);
    burst_left--;
    // the predictor always runs so its state stays in step with the block
    n = encode_byte(b, lst, run);
    if (n_typed != 3'd0) begin
      n = int'(n_typed);
      for (int k = 0; k < n; k++) run[k] = typed[8*(n-1-k) +: 8];
    end
    for (int k = 0; k < n; k++) begin
      char_q.push_back('{out_char: run[k], last_of_run: (k == n-1),
                         end_of_message: (k == n-1) && lst});
    end
  endtask

  // stop sending and wait for every owed character plus a short settle time
  task automatic drain_encoder();
    @(negedge clk);
    in_valid <= 1'b0;
    while (char_q.size() != 0) @(negedge clk);
    repeat (CFG_PAUSE) @(negedge clk);
  endtask

  // register write, only ever issued once the encoder owes no characters
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    drain_encoder();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_WRAP_ENABLE) begin
      enc_wrap = val[0];
    end else if (idx == CFG_LINE_LENGTH) begin
      enc_line_len = val;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: always ready, random stalls drawn each cycle, or occasional long stalls
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            rx_hold   <= $urandom_range(1, 12);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // compare each character transaction with the oldest owed character
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (char_q.size() == 0) begin
        report_mismatch("character with nothing owed", out_data.out_char, 8'h00);
      end else begin
        want = char_q.pop_front();
        if (out_data.out_char !== want.out_char) begin
          report_mismatch("out_char", out_data.out_char, want.out_char);
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          report_mismatch("last_of_run", {7'd0, out_data.last_of_run}, {7'd0, want.last_of_run});
        end
        if (out_data.end_of_message !== want.end_of_message) begin
          report_mismatch("end_of_message", {7'd0, out_data.end_of_message},
                          {7'd0, want.end_of_message});
        end
      end
    end
  end

  // watchdog: too long without any transaction ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int                    msg_len;
    int                    sent;
    logic                  unterminated;
    logic [CFG_DATA_W-1:0] wrap_val;
    logic [CFG_DATA_W-1:0] len_val;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TAB[r].kind == ROW_CFG) begin
        write_reg(DIR_TAB[r].reg_idx, DIR_TAB[r].reg_val);
      end else begin
        send_byte(DIR_TAB[r].data_byte, DIR_TAB[r].last_byte, DIR_TAB[r].n_typed,
                  DIR_TAB[r].typed);
      end
    end

    // random phases, each with its own line setup, sender gaps and receiver pattern
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      gap_max = (ph % 2 == 0) ? 8 : 0;
      rx_mode = ph % 3;
      // upper data bits are random to show the write is masked to one bit
      wrap_val = CFG_DATA_W'($urandom_range(0, 1023));
      wrap_val[0] = !(ph == 2 || ph == 5);
      write_reg(CFG_WRAP_ENABLE, wrap_val);
      len_val = (ph == NUM_PHASES - 1) ? CFG_DATA_W'($urandom_range(0, 1023)) : LEN_PICK[ph];
      write_reg(CFG_LINE_LENGTH, len_val);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        // mostly short messages, now and then a longer one that the byte budget may cut
        msg_len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 9);
        // the phase ends on its byte budget
        if (msg_len > PHASE_BYTES - sent) msg_len = PHASE_BYTES - sent;
        // sometimes the closing flag is missing and the message runs into the next
        unterminated = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < msg_len; i++) begin
          send_byte(8'($urandom_range(0, 255)), (i == msg_len - 1) && !unterminated,
                    3'd0, 40'h0);
          sent++;
        end
      end
    end

    drain_encoder();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
